FILE: rtl/sliding_window_median_filter_defines.svh
// Assertion macros for the sliding window median filter.
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SWMF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SWMF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/swmf_pkg.sv
// Constants, types and the sorting step shared by the median filter modules.
package swmf_pkg;

  localparam int WINDOW      = 3;
  localparam int MAX_WIDTH   = 1024;
  localparam int HALF        = (WINDOW - 1) / 2;
  localparam int LINES       = WINDOW - 1;
  localparam int LINE_LEN    = MAX_WIDTH + HALF;
  localparam int TAPS        = WINDOW * WINDOW;
  localparam int MID         = TAPS / 2;

  localparam int COL_W       = $clog2(LINE_LEN);
  localparam int EXT_COL_W   = $clog2(LINE_LEN + 1);
  localparam int ROW_W       = 17;

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 16;

  localparam logic [CFG_IDX_W-1:0]    CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0]    CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET      = CFG_WIDTH_W'(1024);
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET     = CFG_HEIGHT_W'(1024);

  // Odd-even transposition sort, a few rounds per register stage.
  localparam int SORT_ROUNDS = 3;
  localparam int SORT_STAGES = (TAPS + SORT_ROUNDS - 1) / SORT_ROUNDS;

  localparam int FIFO_DEPTH  = 2 ** $clog2(SORT_STAGES + 4);
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

  typedef logic [7:0] pix_t;
  typedef pix_t [TAPS-1:0] tap_vec_t;
  typedef pix_t [LINES-1:0] line_word_t;
  typedef pix_t [WINDOW-1:0][WINDOW-1:0] win_t;

  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
  } tag_t;

  typedef struct packed {
    pix_t median;
    logic last;
  } out_entry_t;

  function automatic tap_vec_t sort_rounds(tap_vec_t v_in, int first);
    tap_vec_t v;
    pix_t     t;
    v = v_in;
    for (int k = 0; k < SORT_ROUNDS; k++) begin
      if (first + k < TAPS) begin
        for (int i = 0; i < TAPS - 1; i++) begin
          if ((i % 2) == ((first + k) % 2) && v[i] > v[i+1]) begin
            t      = v[i];
            v[i]   = v[i+1];
            v[i+1] = t;
          end
        end
      end
    end
    return v;
  endfunction

endpackage

FILE: rtl/swmf_median.sv
// Pipelined sorting network that picks the median of one window.
module swmf_median (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  swmf_pkg::tag_t      in_tag_i,
  input  swmf_pkg::tap_vec_t  in_vals_i,
  output swmf_pkg::tag_t      out_tag_o,
  output swmf_pkg::pix_t      out_median_o
);

  swmf_pkg::tap_vec_t stage_in [swmf_pkg::SORT_STAGES];
  swmf_pkg::tag_t     tag_in   [swmf_pkg::SORT_STAGES];
  swmf_pkg::tap_vec_t stage_q  [swmf_pkg::SORT_STAGES];
  swmf_pkg::tag_t     tag_q    [swmf_pkg::SORT_STAGES];

  for (genvar s = 0; s < swmf_pkg::SORT_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign stage_in[s] = in_vals_i;
      assign tag_in[s]   = in_tag_i;
    end else begin : g_next
      assign stage_in[s] = stage_q[s-1];
      assign tag_in[s]   = tag_q[s-1];
    end

    always_ff @(posedge clk_i) begin
      stage_q[s] <= swmf_pkg::sort_rounds(stage_in[s], s * swmf_pkg::SORT_ROUNDS);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[s] <= '0;
      end else begin
        tag_q[s] <= tag_in[s];
      end
    end
  end

  assign out_tag_o    = tag_q[swmf_pkg::SORT_STAGES-1];
  assign out_median_o = stage_q[swmf_pkg::SORT_STAGES-1][swmf_pkg::MID];

endmodule

FILE: rtl/sliding_window_median_filter.sv
// Zero padded sliding window median filter: line memory, window, sorter, output queue.
// Items pass stage 0, stage 1 and the SORT_STAGES sorter stages to the output queue.
// Throughput: one item per cycle; the output queue of FIFO_DEPTH entries takes results
// while the sink stalls, and the input stalls once accepted items fill its credit.
// Reset: 1024 x 1024 image, window zero, frame position zero; the line memory is not
// cleared (no clearing pass), rows above the image are masked to zero instead.
`include "sliding_window_median_filter_defines.svh"

module sliding_window_median_filter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               in_cmd_i,
  input  logic [7:0]                         in_pixel_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [7:0]                         out_median_o,
  output logic                               out_last_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [swmf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [swmf_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int COL_W  = swmf_pkg::COL_W;
  localparam int XW     = swmf_pkg::EXT_COL_W;
  localparam int ROW_W  = swmf_pkg::ROW_W;
  localparam int WIN    = swmf_pkg::WINDOW;
  localparam int LINES  = swmf_pkg::LINES;
  localparam int AW     = swmf_pkg::FIFO_AW;
  localparam int CNT_W  = swmf_pkg::CNT_W;

  // Configuration
  logic [swmf_pkg::CFG_WIDTH_W-1:0]  cfg_width_q;
  logic [swmf_pkg::CFG_HEIGHT_W-1:0] cfg_height_q;
  logic                              cfg_restart;

  assign cfg_ready_o = 1'b1;
  assign cfg_restart = cfg_valid_i && (cfg_index_i == swmf_pkg::CFG_IMAGE_WIDTH ||
                                       cfg_index_i == swmf_pkg::CFG_IMAGE_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= swmf_pkg::WIDTH_RESET;
      cfg_height_q <= swmf_pkg::HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        swmf_pkg::CFG_IMAGE_WIDTH:  cfg_width_q  <= cfg_data_i[swmf_pkg::CFG_WIDTH_W-1:0];
        swmf_pkg::CFG_IMAGE_HEIGHT: cfg_height_q <= cfg_data_i[swmf_pkg::CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [XW-1:0]    eff_w;
  logic [XW-1:0]    w_lim;
  logic [ROW_W-1:0] eff_h;
  logic [ROW_W-1:0] h_lim;

  always_comb begin
    if (cfg_width_q == '0) begin
      eff_w = XW'(1);
    end else if (32'(cfg_width_q) > 32'(swmf_pkg::MAX_WIDTH)) begin
      eff_w = XW'(swmf_pkg::MAX_WIDTH);
    end else begin
      eff_w = XW'(cfg_width_q);
    end
    eff_h = (cfg_height_q == '0) ? ROW_W'(1) : ROW_W'(cfg_height_q);
    w_lim = eff_w + XW'(swmf_pkg::HALF);
    h_lim = eff_h + ROW_W'(swmf_pkg::HALF);
  end

  // Frame position and input side
  logic [ROW_W-1:0] pos_row_q, pos_row_d;
  logic [COL_W-1:0] pos_col_q, pos_col_d;
  logic [ROW_W-1:0] row_cur;
  logic [COL_W-1:0] col_cur;
  logic             in_acc;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign in_stall_o = cnt_q >= CNT_W'(swmf_pkg::FIFO_DEPTH);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign row_cur    = (pos_row_q >= h_lim) ? '0 : pos_row_q;
  assign col_cur    = (XW'(pos_col_q) >= w_lim) ? '0 : pos_col_q;

  always_comb begin
    pos_row_d = pos_row_q;
    pos_col_d = pos_col_q;
    if (cfg_restart) begin
      pos_row_d = '0;
      pos_col_d = '0;
    end else if (in_acc) begin
      if (XW'(col_cur) + XW'(1) >= w_lim) begin
        pos_col_d = '0;
        pos_row_d = (row_cur + ROW_W'(1) >= h_lim) ? '0 : row_cur + ROW_W'(1);
      end else begin
        pos_col_d = col_cur + COL_W'(1);
        pos_row_d = row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_row_q <= '0;
      pos_col_q <= '0;
    end else begin
      pos_row_q <= pos_row_d;
      pos_col_q <= pos_col_d;
    end
  end

  // Stage 0: item registered, line memory read issued
  swmf_pkg::tag_t   s0_tag_q;
  swmf_pkg::pix_t   s0_pix_q;
  logic [COL_W-1:0] s0_addr_q;
  logic [LINES-1:0] s0_rmask_q;
  logic [WIN-1:0]   s0_cmask_q;
  swmf_pkg::tag_t   s0_tag_d;
  swmf_pkg::pix_t   s0_pix_d;
  logic [LINES-1:0] s0_rmask_d;
  logic [WIN-1:0]   s0_cmask_d;

  always_comb begin
    s0_tag_d.valid = in_acc;
    s0_tag_d.emit  = row_cur >= ROW_W'(swmf_pkg::HALF) &&
                     XW'(col_cur) >= XW'(swmf_pkg::HALF);
    s0_tag_d.last  = row_cur == h_lim - ROW_W'(1) && XW'(col_cur) == w_lim - XW'(1);
    // padding positions read as zero whatever the command says
    s0_pix_d = (!in_cmd_i && row_cur < eff_h && XW'(col_cur) < eff_w) ? in_pixel_i : '0;
    for (int k = 0; k < LINES; k++) begin
      s0_rmask_d[k] = row_cur >= ROW_W'(k + 1);
    end
    for (int i = 0; i < WIN; i++) begin
      s0_cmask_d[i] = XW'(col_cur) >= XW'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_tag_q <= '0;
    end else begin
      s0_tag_q <= s0_tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s0_pix_q   <= s0_pix_d;
      s0_addr_q  <= col_cur;
      s0_rmask_q <= s0_rmask_d;
      s0_cmask_q <= s0_cmask_d;
    end
  end

  // Line memory: one word per column holds the last LINES rows
  swmf_pkg::line_word_t line_mem [swmf_pkg::LINE_LEN];
  swmf_pkg::line_word_t rd_data_q;
  swmf_pkg::line_word_t wr_data;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_data_q <= line_mem[col_cur];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_tag_q.valid) begin
      line_mem[s0_addr_q] <= wr_data;
    end
  end

  // Stage 1: shift the column into the window, push rows down in memory
  swmf_pkg::pix_t [WIN-1:0] col;
  swmf_pkg::win_t           window_q, window_d;
  swmf_pkg::tag_t           s1_tag_q;
  logic [WIN-1:0]           s1_cmask_q;
  swmf_pkg::tap_vec_t       vals;

  always_comb begin
    col[0]     = s0_pix_q;
    wr_data[0] = s0_pix_q;
    for (int j = 1; j < WIN; j++) begin
      col[j] = s0_rmask_q[j-1] ? rd_data_q[j-1] : '0;
    end
    for (int k = 1; k < LINES; k++) begin
      wr_data[k] = rd_data_q[k-1];
    end
    for (int j = 0; j < WIN; j++) begin
      window_d[j][0] = col[j];
      for (int i = 1; i < WIN; i++) begin
        window_d[j][i] = window_q[j][i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      s1_tag_q <= '0;
    end else begin
      s1_tag_q <= s0_tag_q;
      if (s0_tag_q.valid) begin
        window_q <= window_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cmask_q <= s0_cmask_q;
  end

  // drop columns left of the image
  always_comb begin
    for (int j = 0; j < WIN; j++) begin
      for (int i = 0; i < WIN; i++) begin
        vals[j*WIN+i] = s1_cmask_q[i] ? window_q[j][i] : '0;
      end
    end
  end

  swmf_pkg::tag_t end_tag;
  swmf_pkg::pix_t end_median;

  swmf_median u_median (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_tag_i     (s1_tag_q),
    .in_vals_i    (vals),
    .out_tag_o    (end_tag),
    .out_median_o (end_median)
  );

  // Output queue
  swmf_pkg::out_entry_t fifo_q [swmf_pkg::FIFO_DEPTH];
  logic [AW:0]          wr_ptr_q, rd_ptr_q;
  logic                 push, pop, drop, fifo_full;

  assign push        = end_tag.valid && end_tag.emit;
  assign drop        = end_tag.valid && !end_tag.emit;
  assign out_valid_o = wr_ptr_q != rd_ptr_q;
  assign pop         = out_valid_o && !out_stall_i;
  assign fifo_full   = wr_ptr_q[AW] != rd_ptr_q[AW] && wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0];

  assign out_median_o = fifo_q[rd_ptr_q[AW-1:0]].median;
  assign out_last_o   = fifo_q[rd_ptr_q[AW-1:0]].last;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q[AW-1:0]] <= '{median: end_median, last: end_tag.last};
    end
  end

  // credit: items accepted and not yet delivered or dropped
  assign cnt_d = cnt_q + CNT_W'(in_acc) - CNT_W'(pop) - CNT_W'(drop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + (AW + 1)'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + (AW + 1)'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  `SWMF_ASSERT_IMP(a_line_mem_no_overlap, s0_tag_q.valid && in_acc, s0_addr_q != col_cur, "line memory write and read hit the same column")
  `SWMF_ASSERT_IMP(a_credit_bound, 1'b1, cnt_q <= CNT_W'(swmf_pkg::FIFO_DEPTH), "credit count above queue depth")
  `SWMF_ASSERT_IMP(a_no_push_full, push, !fifo_full, "result pushed into a full output queue")
  `SWMF_ASSERT_NXT(a_result_queued, push, out_valid_o, "pushed result not visible at output")

endmodule
